@@ rtl/dat_pkg.sv @@
// Package for the delayed-action timer table.
// Holds the slot record, command and status codes, and the types passed between
// the scan controller and the result stage. It depends on nothing else.
package dat_pkg;

    localparam int SLOT_COUNT_DEF = 20;

    localparam logic [2:0] KIND_START_DAEMON = 3'd0;
    localparam logic [2:0] KIND_REMOVE       = 3'd1;
    localparam logic [2:0] KIND_START_FUSE   = 3'd2;
    localparam logic [2:0] KIND_LENGTHEN     = 3'd3;
    localparam logic [2:0] KIND_RUN_DAEMONS  = 3'd4;
    localparam logic [2:0] KIND_TICK_FUSES   = 3'd5;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    localparam logic [1:0] CLASS_EMPTY = 2'd0;

    localparam logic signed [15:0] TURNS_DAEMON = -16'sd1;
    localparam logic signed [15:0] TURNS_MAX    = 16'sh7fff;
    localparam logic signed [15:0] TURNS_MIN    = 16'sh8000;

    typedef struct packed {
        logic [1:0]          cls;
        logic [7:0]          cb;
        logic signed [15:0]  arg;
        logic signed [15:0]  turns;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef struct packed {
        logic                hit;
        logic                done;
        logic [7:0]          id;
        logic signed [15:0]  arg;
        logic [1:0]          status;
    } emit_t;

    typedef struct packed {
        logic out_free;
        logic pend_vld;
    } res_state_t;

endpackage

@@ rtl/dat_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM with a registered read.
// Used for the slot store of the delayed-action timer table; no dependencies.
module dat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/dat_ctrl.sv @@
// Scan controller of the delayed-action timer table.
// Walks the slot RAM one entry per cycle unless the result stage stalls it,
// applies each command and writes back. Depends on dat_pkg.
module dat_ctrl
    import dat_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  logic [2:0]         kind,
    input  logic [7:0]         callback_id,
    input  logic signed [15:0] argument,
    input  logic signed [15:0] turns,
    input  logic [1:0]         action_class,
    output logic               rd_en,
    output logic [ADDR_W-1:0]  rd_addr,
    input  logic [SLOT_W-1:0]  rd_data,
    output logic               wr_en,
    output logic [ADDR_W-1:0]  wr_addr,
    output logic [SLOT_W-1:0]  wr_data,
    output emit_t              emit,
    input  res_state_t         res_state
);

    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        issue_cnt_reg, issue_cnt_next;
    logic                    e_vld_reg, e_vld_next;
    logic [ADDR_W-1:0]       e_idx_reg, e_idx_next;
    logic [SLOT_COUNT-1:0]   valid_reg, valid_next;
    logic [1:0]              status_reg, status_next;
    logic [2:0]              kind_reg;
    logic [7:0]              id_reg;
    logic signed [15:0]      arg_reg;
    logic signed [15:0]      turns_reg;
    logic [1:0]              cls_reg;

    slot_t                   cur;
    slot_t                   upd;
    logic [1:0]              cls_q;
    logic                    found;
    logic                    hit;
    logic                    do_write;
    logic                    clear_slot;
    logic                    set_slot;
    logic                    advance;
    logic                    issue;
    logic                    accept;
    logic signed [16:0]      sum;
    logic signed [15:0]      dec;

    assign cur       = slot_t'(rd_data);
    assign cls_q     = valid_reg[e_idx_reg] ? cur.cls : CLASS_EMPTY;
    assign sum       = 17'(cur.turns) + 17'(turns_reg);
    assign dec       = cur.turns - 16'sd1;
    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        found      = 1'b0;
        hit        = 1'b0;
        do_write   = 1'b0;
        clear_slot = 1'b0;
        set_slot   = 1'b0;
        upd        = cur;
        case (kind_reg) inside
            KIND_START_DAEMON, KIND_START_FUSE:
            begin
                found     = (cls_q == CLASS_EMPTY);
                do_write  = found;
                set_slot  = found && (cls_reg != CLASS_EMPTY);
                upd.cls   = cls_reg;
                upd.cb    = id_reg;
                upd.arg   = arg_reg;
                upd.turns = (kind_reg == KIND_START_DAEMON) ? TURNS_DAEMON : turns_reg;
            end
            KIND_REMOVE:
            begin
                found      = (cls_q != CLASS_EMPTY) && (cur.cb == id_reg);
                clear_slot = found;
            end
            KIND_LENGTHEN:
            begin
                found    = (cls_q != CLASS_EMPTY) && (cur.cb == id_reg);
                do_write = found;
                if (sum[16] != sum[15])
                begin
                    upd.turns = sum[16] ? TURNS_MIN : TURNS_MAX;
                end
                else
                begin
                    upd.turns = sum[15:0];
                end
            end
            KIND_RUN_DAEMONS:
            begin
                hit = (cls_q == cls_reg) && (cur.turns == TURNS_DAEMON);
            end
            KIND_TICK_FUSES:
            begin
                do_write   = (cls_q == cls_reg) && !cur.turns[15] && (cur.turns != 16'sd0);
                upd.turns  = dec;
                hit        = do_write && (dec == 16'sd0);
                clear_slot = hit;
            end
            default:
            begin
                found = 1'b0;
            end
        endcase
        if (!(e_vld_reg && (state_reg == ST_SCAN)))
        begin
            found      = 1'b0;
            hit        = 1'b0;
            do_write   = 1'b0;
            clear_slot = 1'b0;
            set_slot   = 1'b0;
        end
    end

    assign advance = !hit || res_state.out_free || !res_state.pend_vld;
    assign issue   = (state_reg == ST_SCAN) && advance && !found
                     && (issue_cnt_reg < CNT_W'(SLOT_COUNT));

    assign rd_en   = issue;
    assign rd_addr = issue_cnt_reg[ADDR_W-1:0];
    assign wr_en   = do_write && advance;
    assign wr_addr = e_idx_reg;
    assign wr_data = upd;

    always_comb
    begin
        emit.hit    = hit && advance;
        emit.done   = (state_reg == ST_FINISH) && res_state.out_free;
        emit.id     = cur.cb;
        emit.arg    = cur.arg;
        emit.status = status_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        issue_cnt_next = issue_cnt_reg;
        e_vld_next     = e_vld_reg;
        e_idx_next     = e_idx_reg;
        valid_next     = valid_reg;
        status_next    = status_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    issue_cnt_next = '0;
                    e_vld_next     = 1'b0;
                    case (kind) inside
                        KIND_START_DAEMON, KIND_START_FUSE:
                        begin
                            status_next = STATUS_FULL;
                            state_next  = ST_SCAN;
                        end
                        KIND_REMOVE, KIND_LENGTHEN:
                        begin
                            status_next = STATUS_NOT_FOUND;
                            state_next  = ST_SCAN;
                        end
                        KIND_RUN_DAEMONS, KIND_TICK_FUSES:
                        begin
                            status_next = STATUS_OK;
                            state_next  = (action_class != CLASS_EMPTY) ? ST_SCAN : ST_FINISH;
                        end
                        default:
                        begin
                            status_next = STATUS_OK;
                            state_next  = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (advance)
                begin
                    if (set_slot)
                    begin
                        valid_next[e_idx_reg] = 1'b1;
                    end
                    if (clear_slot)
                    begin
                        valid_next[e_idx_reg] = 1'b0;
                    end
                    if (issue)
                    begin
                        issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                    end
                    e_vld_next = issue;
                    e_idx_next = issue_cnt_reg[ADDR_W-1:0];
                    if (found)
                    begin
                        status_next = STATUS_OK;
                        state_next  = ST_FINISH;
                    end
                    else if (e_vld_reg && (e_idx_reg == ADDR_W'(SLOT_COUNT - 1)))
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                e_vld_next = 1'b0;
                if (res_state.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_cnt_reg <= '0;
            e_vld_reg     <= 1'b0;
            e_idx_reg     <= '0;
            valid_reg     <= '0;
            status_reg    <= STATUS_OK;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            e_vld_reg     <= e_vld_next;
            e_idx_reg     <= e_idx_next;
            valid_reg     <= valid_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind;
            id_reg    <= callback_id;
            arg_reg   <= argument;
            turns_reg <= turns;
            cls_reg   <= action_class;
        end
    end

endmodule

@@ rtl/dat_out.sv @@
// Result stage of the delayed-action timer table.
// Holds one pending call so the final beat can be marked, plus the output register.
// Depends on dat_pkg.
module dat_out
    import dat_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  emit_t              emit,
    output res_state_t         res_state,
    output logic               res_valid,
    input  logic               res_stall,
    output logic               call_valid,
    output logic [7:0]         call_id,
    output logic signed [15:0] call_argument,
    output logic [1:0]         status,
    output logic               last
);

    logic               out_valid_reg, out_valid_next;
    logic               pend_vld_reg, pend_vld_next;
    logic               call_valid_reg, call_valid_next;
    logic [7:0]         call_id_reg, call_id_next;
    logic signed [15:0] call_arg_reg, call_arg_next;
    logic [1:0]         status_reg, status_next;
    logic               last_reg, last_next;
    logic [7:0]         pend_id_reg, pend_id_next;
    logic signed [15:0] pend_arg_reg, pend_arg_next;

    assign res_state.out_free = !out_valid_reg || !res_stall;
    assign res_state.pend_vld = pend_vld_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg && res_stall;
        pend_vld_next   = pend_vld_reg;
        call_valid_next = call_valid_reg;
        call_id_next    = call_id_reg;
        call_arg_next   = call_arg_reg;
        status_next     = status_reg;
        last_next       = last_reg;
        pend_id_next    = pend_id_reg;
        pend_arg_next   = pend_arg_reg;
        if (emit.hit)
        begin
            if (pend_vld_reg)
            begin
                out_valid_next  = 1'b1;
                call_valid_next = 1'b1;
                call_id_next    = pend_id_reg;
                call_arg_next   = pend_arg_reg;
                status_next     = STATUS_OK;
                last_next       = 1'b0;
            end
            pend_vld_next = 1'b1;
            pend_id_next  = emit.id;
            pend_arg_next = emit.arg;
        end
        else if (emit.done)
        begin
            out_valid_next = 1'b1;
            last_next      = 1'b1;
            pend_vld_next  = 1'b0;
            if (pend_vld_reg)
            begin
                call_valid_next = 1'b1;
                call_id_next    = pend_id_reg;
                call_arg_next   = pend_arg_reg;
                status_next     = STATUS_OK;
            end
            else
            begin
                call_valid_next = 1'b0;
                call_id_next    = '0;
                call_arg_next   = '0;
                status_next     = emit.status;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_vld_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_vld_reg  <= pend_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        call_valid_reg <= call_valid_next;
        call_id_reg    <= call_id_next;
        call_arg_reg   <= call_arg_next;
        status_reg     <= status_next;
        last_reg       <= last_next;
        pend_id_reg    <= pend_id_next;
        pend_arg_reg   <= pend_arg_next;
    end

    assign res_valid     = out_valid_reg;
    assign call_valid    = call_valid_reg;
    assign call_id       = call_id_reg;
    assign call_argument = call_arg_reg;
    assign status        = status_reg;
    assign last          = last_reg;

endmodule

@@ rtl/delayed_action_timer_table.sv @@
// Top level of the delayed-action timer table: slot RAM, scan controller and result stage.
// Depends on dat_pkg, dat_ram, dat_ctrl and dat_out.
//
// The table keeps its slots in one synchronous RAM and handles one command at a time.
// Each command walks the slots from the lowest upwards, one slot per cycle through the
// single read port, and the next command is taken once the final beat of the command has
// been registered on the result channel; start, remove and lengthen stop at the first
// slot that fits, and run or tick with class zero and the unused kinds skip the scan and
// go straight to the finish state. A scan pauses while a call beat is held up by stall
// on the result channel. Occupancy lives in per-slot flip-flops cleared by reset, so the
// block is ready straight after reset.
module delayed_action_timer_table
    import dat_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  logic [2:0]         kind,
    input  logic [7:0]         callback_id,
    input  logic signed [15:0] argument,
    input  logic signed [15:0] turns,
    input  logic [1:0]         action_class,
    output logic               res_valid,
    input  logic               res_stall,
    output logic               call_valid,
    output logic [7:0]         call_id,
    output logic signed [15:0] call_argument,
    output logic [1:0]         status,
    output logic               last
);

    localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [SLOT_W-1:0] rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [SLOT_W-1:0] wr_data;
    emit_t             emit;
    res_state_t        res_state;

    dat_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dat_ctrl #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .kind         (kind),
        .callback_id  (callback_id),
        .argument     (argument),
        .turns        (turns),
        .action_class (action_class),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .emit         (emit),
        .res_state    (res_state)
    );

    dat_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .emit          (emit),
        .res_state     (res_state),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .call_valid    (call_valid),
        .call_id       (call_id),
        .call_argument (call_argument),
        .status        (status),
        .last          (last)
    );

endmodule
